[rtl/smu_pkg.sv]
package smu_pkg;

  localparam int unsigned MaxDim   = 8;
  localparam int unsigned IdxW     = $clog2(MaxDim);
  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned Depth    = MaxDim * MaxDim;
  localparam int unsigned DataW    = 32;
  localparam int unsigned DimW     = 4;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    CMD_WR_A  = 2'd0,
    CMD_WR_B  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_MUL   = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_TRANS = 2'd2,
    MODE_SCALE = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OP_MODE = 3'd0,
    REG_A_ROWS  = 3'd1,
    REG_A_COLS  = 3'd2,
    REG_B_ROWS  = 3'd3,
    REG_B_COLS  = 3'd4,
    REG_SCALE   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    mode_e                   mode;
    logic [IdxW-1:0]         ar_m1;
    logic [IdxW-1:0]         ac_m1;
    logic [IdxW-1:0]         br_m1;
    logic [IdxW-1:0]         bc_m1;
    logic signed [DataW-1:0] scale;
  } cfg_t;

  // Clamps a dimension to 1..MaxDim and returns it minus one.
  function automatic logic [IdxW-1:0] dim_m1(logic [DimW-1:0] d);
    logic [IdxW-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (32'(d) > MaxDim) begin
      r = IdxW'(MaxDim - 1);
    end else begin
      r = IdxW'(d - 1'b1);
    end
    return r;
  endfunction

endpackage

[rtl/smu_if.sv]
interface smu_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [smu_pkg::DimW-1:0]          row;
  logic [smu_pkg::DimW-1:0]          col;
  logic signed [smu_pkg::DataW-1:0]  value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface smu_out_if;
  logic                              valid;
  logic                              ready;
  logic [smu_pkg::DimW-1:0]          out_row;
  logic [smu_pkg::DimW-1:0]          out_col;
  logic signed [smu_pkg::DataW-1:0]  out_value;
  logic                              dim_error;
  logic                              last;

  modport source (output valid, out_row, out_col, out_value, dim_error, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, dim_error, last, output ready);
endinterface

[rtl/smu_store.sv]
module smu_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [smu_pkg::AddrW-1:0]   waddr_i,
  input  logic [smu_pkg::DataW-1:0]   wdata_i,
  input  logic [smu_pkg::AddrW-1:0]   raddr_i,
  output logic [smu_pkg::DataW-1:0]   rdata_o
);

  logic [smu_pkg::DataW-1:0] mem_q [smu_pkg::Depth];
  logic [smu_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/smu_engine.sv]
module smu_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smu_pkg::cfg_t               cfg_i,
  input  logic                        start_i,
  output logic                        idle_o,
  output logic [smu_pkg::AddrW-1:0]   raddr_a_o,
  output logic [smu_pkg::AddrW-1:0]   raddr_b_o,
  input  logic [smu_pkg::DataW-1:0]   rdata_a_i,
  input  logic [smu_pkg::DataW-1:0]   rdata_b_i,
  smu_out_if.source                   out_o
);

  localparam int unsigned IW = smu_pkg::IdxW;
  localparam int unsigned DW = smu_pkg::DataW;
  localparam int unsigned NW = smu_pkg::DimW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ERR
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic            s1_valid_q, s1_first_q, s1_last_q;
  logic            s2_valid_q, s2_first_q, s2_last_q;
  logic [DW-1:0]   term_q, term_d;
  logic [DW-1:0]   acc_q;
  logic            acc_done_q, acc_done_d;
  logic            out_valid_q, out_valid_d;
  logic [NW-1:0]   out_row_q, out_row_d, out_col_q, out_col_d;
  logic [DW-1:0]   out_value_q, out_value_d;
  logic            out_err_q, out_err_d, out_last_q, out_last_d;

  logic [IW-1:0]   rr_m1, rc_m1, kn_m1;
  logic            dim_err, issue, slot_free, emit, elem_last;
  logic [DW-1:0]   mul_b, mult_lo;

  always_comb begin
    unique case (cfg_i.mode)
      smu_pkg::MODE_MUL: begin
        rr_m1   = cfg_i.ar_m1;
        rc_m1   = cfg_i.bc_m1;
        kn_m1   = cfg_i.ac_m1;
        dim_err = cfg_i.ac_m1 != cfg_i.br_m1;
      end
      smu_pkg::MODE_ADD: begin
        rr_m1   = cfg_i.ar_m1;
        rc_m1   = cfg_i.ac_m1;
        kn_m1   = '0;
        dim_err = (cfg_i.ar_m1 != cfg_i.br_m1) || (cfg_i.ac_m1 != cfg_i.bc_m1);
      end
      smu_pkg::MODE_TRANS: begin
        rr_m1   = cfg_i.ac_m1;
        rc_m1   = cfg_i.ar_m1;
        kn_m1   = '0;
        dim_err = 1'b0;
      end
      smu_pkg::MODE_SCALE: begin
        rr_m1   = cfg_i.ar_m1;
        rc_m1   = cfg_i.ac_m1;
        kn_m1   = '0;
        dim_err = 1'b0;
      end
      default: begin
        rr_m1   = '0;
        rc_m1   = '0;
        kn_m1   = '0;
        dim_err = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cfg_i.mode)
      smu_pkg::MODE_MUL: begin
        raddr_a_o = {i_q, k_q};
        raddr_b_o = {k_q, j_q};
      end
      smu_pkg::MODE_TRANS: begin
        raddr_a_o = {j_q, i_q};
        raddr_b_o = {j_q, i_q};
      end
      default: begin
        raddr_a_o = {i_q, j_q};
        raddr_b_o = {i_q, j_q};
      end
    endcase
  end

  // Read data arrives in the cycle after issue; the term is registered before it is accumulated.
  assign mul_b   = (cfg_i.mode == smu_pkg::MODE_SCALE) ? cfg_i.scale : rdata_b_i;
  assign mult_lo = rdata_a_i * mul_b;

  always_comb begin
    unique case (cfg_i.mode)
      smu_pkg::MODE_ADD:   term_d = rdata_a_i + rdata_b_i;
      smu_pkg::MODE_TRANS: term_d = rdata_a_i;
      default:             term_d = mult_lo;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= k_q == '0;
    s1_last_q  <= k_q == kn_m1;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    term_q     <= term_d;
    if (s2_valid_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + term_q;
    end
  end

  assign issue     = state_q == ST_ISSUE;
  assign slot_free = !out_valid_q || out_o.ready;
  assign elem_last = (i_q == rr_m1) && (j_q == rc_m1);
  assign emit      = (state_q == ST_WAIT) && acc_done_q && slot_free;
  assign idle_o    = state_q == ST_IDLE;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_done_d  = acc_done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    if (s2_valid_q && s2_last_q) begin
      acc_done_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d = '0;
          j_d = '0;
          k_d = '0;
          state_d = dim_err ? ST_ERR : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == kn_m1) begin
          k_d     = '0;
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (emit) begin
          acc_done_d  = 1'b0;
          out_valid_d = 1'b1;
          out_row_d   = NW'(i_q) + 1'b1;
          out_col_d   = NW'(j_q) + 1'b1;
          out_value_d = acc_q;
          out_err_d   = 1'b0;
          out_last_d  = elem_last;
          if (elem_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (j_q == rc_m1) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_row_d   = '0;
          out_col_d   = '0;
          out_value_d = '0;
          out_err_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      acc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_err_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      acc_done_q  <= acc_done_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_value_q <= out_value_d;
      out_err_q   <= out_err_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_value_q;
  assign out_o.dim_error = out_err_q;
  assign out_o.last      = out_last_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> state_q == ST_WAIT)
    else $error("Accumulated element pending outside the wait state.");

  a_pipe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q || s2_valid_q) |-> (state_q == ST_ISSUE || state_q == ST_WAIT))
    else $error("Read pipeline active while the engine is idle.");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && elem_last) |=> state_q == ST_IDLE)
    else $error("Run did not end after its final element.");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_last_q && out_value_q == '0))
    else $error("Dimension error transaction is malformed.");

endmodule

[rtl/small_matrix_unit.sv]
// Channel  Direction  Transaction
// in_i     sink       cmd, row, col, value (element load or start)
// out_o    source     out_row, out_col, out_value, dim_error, last
// cfg      write      cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// A start emits its results element by element; each element issues K reads, where K is a_cols
// for a multiply and 1 otherwise, through the single read port of each store, and passes
// through the registered multiply and accumulate behind it before the next element starts.
// A shape mismatch gives a single error transaction in place of the results.
// in_i is ready only while no run is active; a stalled out_o holds the run at its next element.
// The stores have no reset and need no clearing pass.
module small_matrix_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  smu_in_if.sink                              in_i,
  smu_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [smu_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [smu_pkg::DataW-1:0]           cfg_wdata_i
);

  localparam int unsigned IW = smu_pkg::IdxW;
  localparam int unsigned NW = smu_pkg::DimW;

  logic [1:0]                 mode_q;
  logic [NW-1:0]              a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [smu_pkg::DataW-1:0]  scale_q;
  smu_pkg::cfg_t              cfg;

  logic                       accept, in_range, we_a, we_b, start, idle;
  logic [IW-1:0]              row_m1, col_m1;
  logic [smu_pkg::AddrW-1:0]  waddr, raddr_a, raddr_b;
  logic [smu_pkg::DataW-1:0]  rdata_a, rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= smu_pkg::MODE_MUL;
      a_rows_q <= NW'(1);
      a_cols_q <= NW'(1);
      b_rows_q <= NW'(1);
      b_cols_q <= NW'(1);
      scale_q  <= smu_pkg::DataW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smu_pkg::REG_OP_MODE: mode_q   <= cfg_wdata_i[1:0];
        smu_pkg::REG_A_ROWS:  a_rows_q <= cfg_wdata_i[NW-1:0];
        smu_pkg::REG_A_COLS:  a_cols_q <= cfg_wdata_i[NW-1:0];
        smu_pkg::REG_B_ROWS:  b_rows_q <= cfg_wdata_i[NW-1:0];
        smu_pkg::REG_B_COLS:  b_cols_q <= cfg_wdata_i[NW-1:0];
        smu_pkg::REG_SCALE:   scale_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.mode  = smu_pkg::mode_e'(mode_q);
  assign cfg.ar_m1 = smu_pkg::dim_m1(a_rows_q);
  assign cfg.ac_m1 = smu_pkg::dim_m1(a_cols_q);
  assign cfg.br_m1 = smu_pkg::dim_m1(b_rows_q);
  assign cfg.bc_m1 = smu_pkg::dim_m1(b_cols_q);
  assign cfg.scale = scale_q;

  assign accept   = in_i.valid && in_i.ready;
  assign in_range = (in_i.row != '0) && (32'(in_i.row) <= smu_pkg::MaxDim) &&
                    (in_i.col != '0) && (32'(in_i.col) <= smu_pkg::MaxDim);
  assign row_m1   = IW'(in_i.row - 1'b1);
  assign col_m1   = IW'(in_i.col - 1'b1);
  assign waddr    = {row_m1, col_m1};
  assign we_a     = accept && in_range && (in_i.cmd == smu_pkg::CMD_WR_A);
  assign we_b     = accept && in_range && (in_i.cmd == smu_pkg::CMD_WR_B);
  assign start    = accept && (in_i.cmd == smu_pkg::CMD_START);
  assign in_i.ready = idle;

  smu_store u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_i.value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smu_store u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_i.value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  smu_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .start_i   (start),
    .idle_o    (idle),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .out_o     (out_o)
  );

endmodule

[tb/small_matrix_unit_tb.sv]
`timescale 1ns / 1ps

module small_matrix_unit_tb;
  import smu_pkg::*;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned SettleCyc  = 12;
  localparam int unsigned RandTarget = 70;

  typedef struct packed {
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [DataW-1:0] value;
    logic             err;
    logic             last;
  } smu_result_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [DataW-1:0] value;
  } load_t;

  class smu_scoreboard;
    logic [DataW-1:0] a_mem [Depth];
    logic [DataW-1:0] b_mem [Depth];
    mode_e            mode;
    logic [DimW-1:0]  ar, ac, br, bc;
    logic [DataW-1:0] scale;
    smu_result_t      matrix_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      dim_errors;

    function new();
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      mode = MODE_MUL;
      ar = DimW'(1);
      ac = DimW'(1);
      br = DimW'(1);
      bc = DimW'(1);
      scale = DataW'(1);
      errors = 0;
      checked = 0;
      dim_errors = 0;
    endfunction

    static function logic [DimW-1:0] clamp(logic [DimW-1:0] d);
      if (d == '0) return DimW'(1);
      if (d > MaxDim) return DimW'(MaxDim);
      return d;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] data);
      case (idx)
        REG_OP_MODE: mode = mode_e'(data[1:0]);
        REG_A_ROWS:  ar = data[DimW-1:0];
        REG_A_COLS:  ac = data[DimW-1:0];
        REG_B_ROWS:  br = data[DimW-1:0];
        REG_B_COLS:  bc = data[DimW-1:0];
        REG_SCALE:   scale = data;
        default: ;
      endcase
    endfunction

    // Records element loads and computes the whole matrix, or the error transaction, that a start produces.
    function void note_input(logic [1:0] cmd, logic [DimW-1:0] row, logic [DimW-1:0] col,
                             logic [DataW-1:0] value);
      int          arc, acc_n, brc, bcc, rr, rc, idx;
      logic [DataW-1:0] v;
      smu_result_t r;
      if (cmd == CMD_WR_A || cmd == CMD_WR_B) begin
        if (row >= 1 && row <= MaxDim && col >= 1 && col <= MaxDim) begin
          idx = (int'(row) - 1) * MaxDim + (int'(col) - 1);
          if (cmd == CMD_WR_A) a_mem[idx] = value;
          else b_mem[idx] = value;
        end
        return;
      end
      if (cmd != CMD_START) return;
      arc = int'(clamp(ar));
      acc_n = int'(clamp(ac));
      brc = int'(clamp(br));
      bcc = int'(clamp(bc));
      if ((mode == MODE_MUL && acc_n != brc) ||
          (mode == MODE_ADD && (arc != brc || acc_n != bcc))) begin
        r = '{row: '0, col: '0, value: '0, err: 1'b1, last: 1'b1};
        matrix_q.push_back(r);
        return;
      end
      rr = (mode == MODE_TRANS) ? acc_n : arc;
      rc = (mode == MODE_MUL) ? bcc : (mode == MODE_TRANS) ? arc : acc_n;
      for (int i = 0; i < rr; i++) begin
        for (int j = 0; j < rc; j++) begin
          case (mode)
            MODE_MUL: begin
              v = '0;
              for (int k = 0; k < acc_n; k++) begin
                v = v + a_mem[i * MaxDim + k] * b_mem[k * MaxDim + j];
              end
            end
            MODE_ADD:   v = a_mem[i * MaxDim + j] + b_mem[i * MaxDim + j];
            MODE_TRANS: v = a_mem[j * MaxDim + i];
            default:    v = a_mem[i * MaxDim + j] * scale;
          endcase
          r.row = DimW'(i + 1);
          r.col = DimW'(j + 1);
          r.value = v;
          r.err = 1'b0;
          r.last = (i == rr - 1) && (j == rc - 1);
          matrix_q.push_back(r);
        end
      end
    endfunction

    function void report(string field, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(smu_result_t got);
      smu_result_t exp_r;
      checked++;
      if (got.err) dim_errors++;
      if (matrix_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual row %0d col %0d value %0h",
                 $time, got.row, got.col, got.value);
        errors++;
        return;
      end
      exp_r = matrix_q.pop_front();
      if (got.row !== exp_r.row) report("out_row", exp_r.row, got.row);
      if (got.col !== exp_r.col) report("out_col", exp_r.col, got.col);
      if (got.value !== exp_r.value) report("out_value", exp_r.value, got.value);
      if (got.err !== exp_r.err) report("dim_error", exp_r.err, got.err);
      if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
    endfunction

    function int pending();
      return matrix_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DataW-1:0]    cfg_wdata_i;

  smu_in_if  in_if ();
  smu_out_if out_if ();

  small_matrix_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  smu_scoreboard sb = new();

  bit          a_written [Depth];
  bit          b_written [Depth];
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  bit          in_random;
  int unsigned n_random;
  int unsigned n_loads;
  int unsigned n_starts;
  int unsigned n_ignored;
  int unsigned n_phases;
  int unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
               sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    smu_result_t got;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_row, out_if.out_col, out_if.out_value, out_if.dim_error,
                out_if.last};
        sb.check_result(got);
      end
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        hold = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_dim(bit big);
    if (big && $urandom_range(0, 1) == 1) return DimW'($urandom_range(8, 15));
    if (big) return DimW'($urandom_range(1, 3));
    return DimW'($urandom_range(0, 3));
  endfunction

  function automatic void queue_loads(ref load_t q[$], input logic [1:0] cmd,
                                      input int rows, input int cols);
    load_t ld;
    bit    done;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        done = (cmd == CMD_WR_A) ? a_written[r * MaxDim + c] : b_written[r * MaxDim + c];
        if (!done || $urandom_range(0, 5) == 0) begin
          ld.cmd = cmd;
          ld.row = DimW'(r + 1);
          ld.col = DimW'(c + 1);
          ld.value = rand_value();
          q.push_back(ld);
        end
      end
    end
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [DimW-1:0] row,
                           input logic [DimW-1:0] col, input logic [DataW-1:0] value);
    bit in_range;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.row <= row;
    in_if.col <= col;
    in_if.value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(cmd, row, col, value);
    in_range = row >= 1 && row <= MaxDim && col >= 1 && col <= MaxDim;
    if (cmd == CMD_START) begin
      n_starts++;
    end else if ((cmd == CMD_WR_A || cmd == CMD_WR_B) && in_range) begin
      n_loads++;
      if (cmd == CMD_WR_A) a_written[(int'(row) - 1) * MaxDim + int'(col) - 1] = 1'b1;
      else b_written[(int'(row) - 1) * MaxDim + int'(col) - 1] = 1'b1;
    end else begin
      n_ignored++;
    end
    if (in_random && (cmd == CMD_START || ((cmd == CMD_WR_A || cmd == CMD_WR_B) && in_range)))
      n_random++;
  endtask

  // Holds the sender until the block has drained every outstanding result.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input bit full_a, input bit calm);
    mode_e           m;
    logic [DimW-1:0] dim [4];
    int              cl [4];
    bit              big;
    bit              err;
    load_t           loads[$];
    load_t           ld;
    int              j;
    settle();
    n_phases++;
    if (calm) begin
      in_gap_pct = 0;
      out_stall_pct = 0;
    end else begin
      in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    end
    m = mode_e'($urandom_range(0, 3));
    big = ($urandom_range(0, 5) == 0);
    for (int d = 0; d < 4; d++) dim[d] = pick_dim(big);
    if (full_a) begin
      m = MODE_TRANS;
      dim[0] = 4'd8;
      dim[1] = 4'd15;
    end
    if (m == MODE_MUL && $urandom_range(0, 3) != 0) dim[2] = dim[1];
    if (m == MODE_ADD && $urandom_range(0, 3) != 0) begin
      dim[2] = dim[0];
      dim[3] = dim[1];
    end
    write_reg(REG_OP_MODE, 32'(m));
    write_reg(REG_A_ROWS, 32'(dim[0]));
    write_reg(REG_A_COLS, 32'(dim[1]));
    write_reg(REG_B_ROWS, 32'(dim[2]));
    write_reg(REG_B_COLS, 32'(dim[3]));
    write_reg(REG_SCALE, rand_value());
    for (int d = 0; d < 4; d++) cl[d] = int'(smu_scoreboard::clamp(dim[d]));
    err = (m == MODE_MUL && cl[1] != cl[2]) ||
          (m == MODE_ADD && (cl[0] != cl[2] || cl[1] != cl[3]));
    if (!err) begin
      queue_loads(loads, CMD_WR_A, cl[0], cl[1]);
      if (m == MODE_MUL) queue_loads(loads, CMD_WR_B, cl[1], cl[3]);
      if (m == MODE_ADD) queue_loads(loads, CMD_WR_B, cl[0], cl[1]);
    end
    repeat ($urandom_range(0, 2)) begin
      ld.cmd = ($urandom_range(0, 1) == 1) ? CMD_WR_B : CMD_WR_A;
      ld.row = DimW'($urandom_range(1, MaxDim));
      ld.col = DimW'($urandom_range(1, MaxDim));
      ld.value = rand_value();
      loads.push_back(ld);
    end
    repeat ($urandom_range(0, 2)) begin
      ld.cmd = ($urandom_range(0, 2) == 0) ? CmdUnused : 2'($urandom_range(0, 1));
      ld.row = ($urandom_range(0, 1) == 1) ? 4'd0 : DimW'($urandom_range(9, 15));
      ld.col = DimW'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) begin
        ld.col = ld.row;
        ld.row = DimW'($urandom_range(0, 15));
      end
      ld.value = $urandom;
      loads.push_back(ld);
    end
    for (int i = loads.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      ld = loads[i];
      loads[i] = loads[j];
      loads[j] = ld;
    end
    foreach (loads[i]) send_item(loads[i].cmd, loads[i].row, loads[i].col, loads[i].value);
    repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
      send_item(CMD_START, DimW'($urandom_range(0, 15)), DimW'($urandom_range(0, 15)),
                $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = '0;
    in_if.row = '0;
    in_if.col = '0;
    in_if.value = '0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: wrapping arithmetic at the value extremes, each operation, both kinds
    // of shape mismatch, clamped dimensions and ignored transactions.
    send_item(CMD_WR_A, 4'd1, 4'd1, 32'h7fff_ffff);
    send_item(CMD_WR_B, 4'd1, 4'd1, 32'h8000_0000);
    send_item(CMD_WR_A, 4'd8, 4'd8, 32'h8000_0000);
    send_item(CMD_WR_B, 4'd8, 4'd8, 32'hffff_ffff);
    send_item(CMD_START, 4'd0, 4'd0, 32'h0);
    settle();
    write_reg(REG_OP_MODE, 32'(MODE_SCALE));
    write_reg(REG_SCALE, 32'h8000_0000);
    send_item(CMD_START, 4'd15, 4'd15, 32'hffff_ffff);
    settle();
    write_reg(REG_OP_MODE, 32'(MODE_ADD));
    send_item(CMD_START, 4'd1, 4'd1, 32'h0);
    settle();
    write_reg(REG_OP_MODE, 32'(MODE_TRANS));
    write_reg(REG_A_ROWS, 32'd0);
    write_reg(REG_A_COLS, 32'd0);
    send_item(CMD_START, 4'd0, 4'd0, 32'h0);
    send_item(CmdUnused, 4'd15, 4'd15, 32'hffff_ffff);
    send_item(CMD_WR_A, 4'd0, 4'd1, 32'h1234_5678);
    send_item(CMD_WR_B, 4'd9, 4'd15, 32'h0bad_f00d);
    send_item(CMD_WR_A, 4'd1, 4'd0, 32'hdead_beef);
    send_item(CMD_START, 4'd0, 4'd0, 32'h0);
    settle();
    write_reg(REG_OP_MODE, 32'(MODE_MUL));
    write_reg(REG_A_ROWS, 32'd1);
    write_reg(REG_A_COLS, 32'd2);
    write_reg(REG_B_ROWS, 32'd3);
    write_reg(REG_B_COLS, 32'd1);
    send_item(CMD_START, 4'd0, 4'd0, 32'h0);
    settle();
    write_reg(REG_OP_MODE, 32'(MODE_ADD));
    write_reg(REG_A_COLS, 32'd1);
    write_reg(REG_B_ROWS, 32'd2);
    send_item(CMD_START, 4'd0, 4'd0, 32'h0);

    in_random = 1'b1;
    while (n_random < RandTarget) run_phase(n_phases == 2, 1'b0);
    repeat (3) run_phase(1'b0, 1'b1);

    settle();
    $display("Covered %0d element loads, %0d starts and %0d ignored transactions over %0d settings.",
             n_loads, n_starts, n_ignored, n_phases + 6);
    $display("Checked %0d result transactions, %0d with dim_error; %0d mismatches.",
             sb.checked, sb.dim_errors, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/smu_pkg.sv
rtl/smu_if.sv
rtl/smu_store.sv
rtl/smu_engine.sv
rtl/small_matrix_unit.sv
tb/small_matrix_unit_tb.sv
